@@ src/lto_pkg.sv @@
// ----------------------------------------------------------------------------
// lto_pkg
// Shared types and constants for the line-table offset lookup.
// ----------------------------------------------------------------------------
package lto_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PAYLOAD_W = 7;
	localparam int unsigned SHIFT_W   = 6;

	// ULEB128 shift step and the saturation point of the shift count
	localparam logic [SHIFT_W-1:0] STEP_BITS = 6'd7;
	localparam logic [SHIFT_W-1:0] SHIFT_CAP = 6'd35;
	localparam logic [SHIFT_W-1:0] SHIFT_LIM = 6'd32;

	// no source offset known
	localparam logic [DATA_W-1:0] NO_SOURCE = '1;

	// one finished varint, handed from the decoder to the entry tracker
	typedef struct packed {
		logic              done;      // a varint ended on this byte
		logic              is_source; // it is the source delta of an entry
		logic [DATA_W-1:0] value;     // assembled value, low 32 bits
	} varint_evt_t;

endpackage

@@ src/lto_varint.sv @@
// ----------------------------------------------------------------------------
// lto_varint
// ULEB128 decoder: assembles one varint per run of bytes and tracks which
// field of the entry it belongs to.
// ----------------------------------------------------------------------------
module lto_varint (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,         // one byte taken this cycle
	input  logic                       first,      // clear before this byte
	input  logic                       last,       // clear after this byte
	input  logic [lto_pkg::BYTE_W-1:0] table_byte,
	output lto_pkg::varint_evt_t       evt
);

	logic [lto_pkg::DATA_W-1:0]  acc_q, acc_in, acc_or;
	logic [lto_pkg::SHIFT_W-1:0] shift_q, shift_in;
	logic                        second_q, second_in;
	logic [lto_pkg::DATA_W-1:0]  part;
	logic                        cont;

	// state as seen by this byte, cleared on the start of a table
	assign acc_in    = first ? '0 : acc_q;
	assign shift_in  = first ? '0 : shift_q;
	assign second_in = first ? 1'b0 : second_q;

	// payload bits at bit 32 and above fall off
	always_comb begin
		part = '0;
		if (shift_in < lto_pkg::SHIFT_LIM) begin
			part = {{(lto_pkg::DATA_W - lto_pkg::PAYLOAD_W){1'b0}},
				table_byte[lto_pkg::PAYLOAD_W-1:0]} << shift_in;
		end
	end

	assign acc_or = acc_in | part;
	assign cont   = table_byte[lto_pkg::BYTE_W-1];

	assign evt.done      = en && !cont;
	assign evt.is_source = second_in;
	assign evt.value     = acc_or;

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			shift_q  <= '0;
			second_q <= 1'b0;
		end else if (en) begin
			if (last) begin
				acc_q    <= '0;
				shift_q  <= '0;
				second_q <= 1'b0;
			end else if (cont) begin
				acc_q    <= acc_or;
				shift_q  <= (shift_in < lto_pkg::SHIFT_CAP) ? shift_in + lto_pkg::STEP_BITS
					: shift_in;
				second_q <= second_in;
			end else begin
				acc_q    <= '0;
				shift_q  <= '0;
				second_q <= !second_in;
			end
		end
	end

endmodule

@@ src/lto_entry.sv @@
// ----------------------------------------------------------------------------
// lto_entry
// Entry tracker: running bytecode and source sums, and the source offset of
// the last entry at or below the query.
// ----------------------------------------------------------------------------
module lto_entry (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       first,
	input  logic                       last,
	input  lto_pkg::varint_evt_t       evt,
	input  logic [lto_pkg::DATA_W-1:0] query_offset,
	output logic [lto_pkg::DATA_W-1:0] result     // valid with a last byte
);

	logic [lto_pkg::DATA_W-1:0] bc_q, pend_q, src_q, best_q;
	logic                       stopped_q;
	logic [lto_pkg::DATA_W-1:0] bc_in, pend_in, src_in, best_in;
	logic                       stopped_in;
	logic [lto_pkg::DATA_W-1:0] bc_n, pend_n, src_n, best_n;
	logic                       stopped_n;
	logic [lto_pkg::DATA_W-1:0] src_delta;

	assign bc_in      = first ? '0 : bc_q;
	assign pend_in    = first ? '0 : pend_q;
	assign src_in     = first ? '0 : src_q;
	assign best_in    = first ? lto_pkg::NO_SOURCE : best_q;
	assign stopped_in = first ? 1'b0 : stopped_q;

	// zigzag decode of the source delta
	assign src_delta = (evt.value >> 1) ^ {lto_pkg::DATA_W{evt.value[0]}};

	// entry completion and query compare
	always_comb begin
		bc_n      = bc_in;
		pend_n    = pend_in;
		src_n     = src_in;
		best_n    = best_in;
		stopped_n = stopped_in;
		if (evt.done) begin
			if (!evt.is_source) begin
				pend_n = evt.value;
			end else begin
				bc_n  = bc_in + pend_in;
				src_n = src_in + src_delta;
				if (!stopped_in) begin
					if ($signed(bc_n) > $signed(query_offset)) begin
						stopped_n = 1'b1;
					end else begin
						best_n = src_n;
					end
				end
			end
		end
	end

	assign result = query_offset[lto_pkg::DATA_W-1] ? lto_pkg::NO_SOURCE : best_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q      <= '0;
			pend_q    <= '0;
			src_q     <= '0;
			best_q    <= lto_pkg::NO_SOURCE;
			stopped_q <= 1'b0;
		end else if (en) begin
			if (last) begin
				bc_q      <= '0;
				pend_q    <= '0;
				src_q     <= '0;
				best_q    <= lto_pkg::NO_SOURCE;
				stopped_q <= 1'b0;
			end else begin
				bc_q      <= bc_n;
				pend_q    <= pend_n;
				src_q     <= src_n;
				best_q    <= best_n;
				stopped_q <= stopped_n;
			end
		end
	end

endmodule

@@ src/line_table_offset_lookup.sv @@
// ----------------------------------------------------------------------------
// line_table_offset_lookup
// Walks an encoded line-number table one byte per transfer and returns the
// source offset in effect at the query bytecode offset.
// ----------------------------------------------------------------------------
// Pipeline: a byte is registered on transfer and decoded from the input register;
//   the result of a last byte is then registered in the output register.
// Throughput: one byte per cycle; the input stage holds only while a result
//   waits in the output register and the staged byte carries another result.
// Reset: arst_n clears handshake state, decoder and sums; query resets to 0.
module line_table_offset_lookup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lto_pkg::DATA_W-1:0] cfg_wdata,  // query_offset
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lto_pkg::BYTE_W-1:0] s_tdata,    // [7:0] table_byte
	input  logic                       s_tuser,    // [0] first_byte
	input  logic                       s_tlast,    // last_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lto_pkg::DATA_W-1:0] m_tdata     // [31:0] source_offset
);

	logic [lto_pkg::DATA_W-1:0] query_q;
	logic                       valid_s1;
	logic [lto_pkg::BYTE_W-1:0] byte_s1;
	logic                       first_s1, last_s1;
	logic                       advance;
	logic                       out_valid_q;
	logic [lto_pkg::DATA_W-1:0] out_data_q;
	logic [lto_pkg::DATA_W-1:0] result;
	lto_pkg::varint_evt_t       evt;

	// query register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (cfg_we) begin
			query_q <= cfg_wdata;
		end
	end

	// staged byte moves on unless its result has nowhere to go
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	lto_varint u_varint (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.first      (first_s1),
		.last       (last_s1),
		.table_byte (byte_s1),
		.evt        (evt)
	);

	lto_entry u_entry (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.first        (first_s1),
		.last         (last_s1),
		.evt          (evt),
		.query_offset (query_q),
		.result       (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ src/lto_checker.sv @@
// ----------------------------------------------------------------------------
// lto_checker
// Port-level checks on the line-table offset lookup.
// ----------------------------------------------------------------------------
module lto_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       s_tuser,
	input logic                       s_tlast,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [lto_pkg::DATA_W-1:0] m_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input only backs up behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// a new result must come from a last-byte transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a last byte");

	// a one-byte table completes no entry
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && $past(s_tvalid && s_tready && s_tlast && s_tuser, 2)
		|-> m_tdata == lto_pkg::NO_SOURCE)
		else $error("one-byte table gave a source offset");

endmodule

bind line_table_offset_lookup lto_checker u_lto_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ tb/sv/tb_line_table_offset_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_table_offset_lookup
// Streams encoded line-number tables into the lookup block and checks each
// returned source offset against a cycle-free model of the table walk.
// Directed tables hit the empty, overlong, stopping, truncated and
// query-change cases; random tables then mix well-formed and broken input
// while both stream sides stall in bursts.
// ----------------------------------------------------------------------------
module tb_line_table_offset_lookup;

	localparam int unsigned TOTAL_BYTES = 2000;
	localparam int unsigned QUIET_FROM  = 1700;  // no idling past this point
	localparam int unsigned TABLES_PER_QUERY = 24;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [lto_pkg::DATA_W-1:0]  cfg_wdata = '0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [lto_pkg::BYTE_W-1:0]  s_tdata = '0;   // [7:0] table_byte
	logic                        s_tuser = 1'b0; // [0] first_byte
	logic                        s_tlast = 1'b0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [lto_pkg::DATA_W-1:0]  m_tdata;        // [31:0] source_offset

	line_table_offset_lookup dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// model state of the table walk
	logic [31:0] q_offset = '0;
	logic [31:0] p_acc;
	logic [5:0]  p_shift;
	logic        p_in_source;
	logic [31:0] p_bc_sum;
	logic [31:0] p_pend_bc;
	logic [31:0] p_src_sum;
	logic [31:0] p_best;
	logic        p_halted;

	logic [31:0] want_source[$];   // source offsets still to come out
	logic [7:0]  tbl_q[$];         // bytes of the table being built

	bit          tx_gaps = 1'b0;
	bit          rx_stalls = 1'b0;
	int unsigned stall_left = 0;
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned tables_sent = 0;
	int unsigned results_seen = 0;

	function automatic void clear_walk();
		p_acc       = '0;
		p_shift     = '0;
		p_in_source = 1'b0;
		p_bc_sum    = '0;
		p_pend_bc   = '0;
		p_src_sum   = '0;
		p_best      = lto_pkg::NO_SOURCE;
		p_halted    = 1'b0;
	endfunction

	// advance the model by one accepted table byte
	function automatic void walk_table_byte(input logic [7:0] data, input logic first,
			input logic last);
		logic [31:0] v;
		if (first)
			clear_walk();
		if (p_shift < lto_pkg::SHIFT_LIM)
			p_acc = p_acc | ({25'd0, data[6:0]} << p_shift);
		if (data[7]) begin
			if (p_shift < lto_pkg::SHIFT_CAP)
				p_shift = p_shift + lto_pkg::STEP_BITS;
		end else begin
			v = p_acc;
			p_acc = '0;
			p_shift = '0;
			if (!p_in_source) begin
				p_pend_bc = v;
				p_in_source = 1'b1;
			end else begin
				// entry done: zigzag source delta, signed compare with the query
				p_in_source = 1'b0;
				p_bc_sum = p_bc_sum + p_pend_bc;
				p_src_sum = p_src_sum + ((v >> 1) ^ {32{v[0]}});
				if (!p_halted) begin
					if ($signed(p_bc_sum) > $signed(q_offset))
						p_halted = 1'b1;
					else
						p_best = p_src_sum;
				end
			end
		end
		if (last) begin
			want_source.push_back(q_offset[31] ? lto_pkg::NO_SOURCE : p_best);
			clear_walk();
		end
	endfunction

	// append one ULEB128 value, with optional overlong zero padding
	function automatic void add_uleb(input logic [31:0] value, input int unsigned pad);
		logic [31:0] rest;
		logic [7:0]  chunk;
		int unsigned pad_left;
		rest = value;
		pad_left = pad;
		forever begin
			chunk = {1'b0, rest[6:0]};
			rest = rest >> 7;
			if (rest == 0 && pad_left == 0) begin
				tbl_q.push_back(chunk);
				break;
			end
			if (rest == 0)
				pad_left--;
			tbl_q.push_back(chunk | 8'h80);
		end
	endfunction

	// one byte transfer on the input stream, model updated on acceptance
	task automatic send_table_byte(input logic [7:0] data, input logic first,
			input logic last);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= first;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		walk_table_byte(data, first, last);
		bytes_sent++;
	endtask

	// send the built table; stray first flags only for noise tables
	task automatic send_table(input bit with_first, input bit with_last,
			input bit stray_first);
		logic first;
		int   n;
		n = tbl_q.size();
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				first = with_first;
			else
				first = stray_first && $urandom_range(0, 3) == 0;
			send_table_byte(tbl_q[i], first, with_last && i == n - 1);
		end
		tbl_q.delete();
		if (with_last)
			tables_sent++;
	endtask

	// wait until every expected result is out and the pipeline is empty
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (want_source.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_query(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		q_offset = value;
	endtask

	// receiver backpressure in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (want_source.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result source_offset=%0d", $realtime,
						$signed(m_tdata));
				mismatches++;
			end else begin
				if (m_tdata !== want_source[0]) begin
					if (mismatches < 10)
						$display("%0t: source_offset expected %0d got %0d", $realtime,
							$signed(want_source[0]), $signed(m_tdata));
					mismatches++;
				end
				void'(want_source.pop_front());
			end
		end
	end

	// reset query value; entry-less tables give no source, a zero entry gives 0
	task automatic test_empty_table();
		tbl_q = '{8'h00};
		send_table(1'b1, 1'b1, 1'b0);
		tbl_q = '{8'h80};
		send_table(1'b1, 1'b1, 1'b0);
		tbl_q = '{8'h00, 8'h00};
		send_table(1'b1, 1'b1, 1'b0);
		drain_block();
	endtask

	// payload past bit 31 dropped, shift count reaching its cap, all-ones bytecode sum
	task automatic test_long_varint();
		write_query(32'h7fff_ffff);
		tbl_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h02};
		send_table(1'b1, 1'b1, 1'b0);
		drain_block();
	endtask

	// walk stops at the first entry past the query; unfinished tail ignored
	task automatic test_stop_and_truncate();
		write_query(32'd10);
		add_uleb(32'd5, 0);
		add_uleb(32'd14, 0);
		add_uleb(32'd5, 0);
		add_uleb(32'd5, 0);
		add_uleb(32'd1, 0);
		add_uleb(32'd100, 0);
		tbl_q.push_back(8'h00);
		tbl_q.push_back(8'h85);
		send_table(1'b1, 1'b1, 1'b0);
		drain_block();
	endtask

	// negative query, query rewritten inside a table, table with no first flag
	task automatic test_query_mid_table();
		write_query(32'h8000_0000);
		tbl_q = '{8'h00, 8'h00};
		send_table(1'b1, 1'b1, 1'b0);
		drain_block();
		write_query(32'd0);
		tbl_q = '{8'h00, 8'h08};
		send_table(1'b1, 1'b0, 1'b0);
		drain_block();
		write_query(32'd3);
		tbl_q = '{8'h03, 8'h02, 8'h01, 8'h02};
		send_table(1'b0, 1'b1, 1'b0);
		tbl_q = '{8'h00, 8'h14};
		send_table(1'b0, 1'b1, 1'b0);
		drain_block();
	endtask

	// mostly well-formed tables with random content, some broken or noise
	task automatic test_random_tables();
		int unsigned        n_tables;
		int unsigned        n_entries;
		int unsigned        kind;
		logic [31:0]        q;
		logic [31:0]        bc;
		logic signed [31:0] src;
		logic [31:0]        zz;
		n_tables = 0;
		while (bytes_sent < TOTAL_BYTES) begin
			if (n_tables % TABLES_PER_QUERY == 0) begin
				drain_block();
				case ($urandom_range(0, 9))
					0: q = 32'h7fff_ffff;
					1: q = 32'h8000_0000;
					2: q = $urandom();
					3: q = '0;
					default: q = $urandom_range(0, 120);
				endcase
				write_query(q);
			end
			if (bytes_sent >= QUIET_FROM) begin
				tx_gaps = 1'b0;
				rx_stalls = 1'b0;
			end else if (n_tables % 8 == 0) begin
				tx_gaps = $urandom_range(0, 3) != 0;
				rx_stalls = $urandom_range(0, 3) != 0;
			end
			kind = $urandom_range(0, 9);
			if (kind < 9) begin
				n_entries = $urandom_range(0, 7);
				for (int e = 0; e < n_entries; e++) begin
					case ($urandom_range(0, 9))
						0: bc = $urandom();
						1, 2: bc = $urandom_range(0, 2000);
						default: bc = $urandom_range(0, 20);
					endcase
					if ($urandom_range(0, 4) == 0) begin
						zz = $urandom();
					end else begin
						src = $signed($urandom_range(0, 200)) - 100;
						zz = {src[30:0], 1'b0} ^ {32{src[31]}};
					end
					add_uleb(bc, $urandom_range(0, 9) == 0 ? $urandom_range(1, 4) : 0);
					add_uleb(zz, $urandom_range(0, 9) == 0 ? $urandom_range(1, 4) : 0);
				end
				// broken tail: a lone bytecode delta and maybe an open varint
				if (kind >= 7 || n_entries == 0) begin
					add_uleb($urandom_range(0, 300), 0);
					if ($urandom_range(0, 1) == 1)
						tbl_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
				end
				send_table(kind != 6, 1'b1, 1'b0);
			end else begin
				repeat ($urandom_range(1, 12))
					tbl_q.push_back(8'($urandom_range(0, 255)));
				send_table($urandom_range(0, 1) == 1, 1'b1, 1'b1);
			end
			n_tables++;
		end
		drain_block();
	endtask

	initial begin
		clear_walk();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		test_long_varint();
		test_stop_and_truncate();
		test_query_mid_table();
		test_random_tables();
		$display("covered %0d table bytes in %0d tables, %0d source offsets checked",
			bytes_sent, tables_sent, results_seen);
		$display("queries from both signed extremes, overlong and truncated varints");
		if (mismatches == 0 && want_source.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", want_source.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
src/lto_pkg.sv
src/lto_varint.sv
src/lto_entry.sv
src/line_table_offset_lookup.sv
src/lto_checker.sv
tb/sv/tb_line_table_offset_lookup.sv
